/* sv/tpi_pkg.sv */
package tpi_pkg;

   localparam int COORD_BITS       = 24;
   localparam int INDEX_BITS       = 32;
   localparam int SIZE_REG_BITS    = 13;
   localparam int RANK_BITS        = 3;
   localparam int MAX_RANK         = 5;
   localparam int MAX_DIM_SIZE_DEF = 4096;
   localparam int CSR_DATA_BITS    = 32;
   localparam int CSR_ADDR_BITS    = 5;

   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] flat_index;
      logic                  overflow;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      CSR_RANK      = 3'd0,
      CSR_ODD_ROW   = 3'd1,
      CSR_SIZE_DIM1 = 3'd2,
      CSR_SIZE_DIM2 = 3'd3,
      CSR_SIZE_DIM3 = 3'd4,
      CSR_SIZE_DIM4 = 3'd5
   } csr_reg_type;

   // bits needed to hold a dimension size up to max_size
   function automatic int dim_bits(input int max_size);
      return $clog2(max_size + 1);
   endfunction

endpackage

/* sv/tensor_projection_2d_index_core.sv */
// Turns a (row, col) coordinate of the 2D projection of a rank 1..5 tensor into its
// row-major flat index. One request is taken per cycle while req_ready is high. The
// pipeline is two chains of restoring divider cells, one quotient bit per cell, that
// split the outer dimensions out of row and col, followed by four multiply-add cells
// that fold the indexes with the dimension sizes. A two-deep output buffer lets
// requests keep flowing while a result waits; when both entries are full, req_ready
// drops and the chains hold.
// Registers (APB, byte address 4*n): rank, odd_row, size_dim1..4. Sizes of 0 act as 1,
// sizes above MAX_DIM_SIZE act as MAX_DIM_SIZE, and a rank outside 1..5 returns index 0.
// An index that does not fit in 32 bits returns all ones with overflow set. Registers
// must only be written while no request is in flight.
module tensor_projection_2d_index_core #(
   parameter int MAX_DIM_SIZE = tpi_pkg::MAX_DIM_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tpi_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tpi_pkg::rsp_payload_type            rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tpi_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [tpi_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [tpi_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);
   import tpi_pkg::*;

   localparam int DIM_W = dim_bits(MAX_DIM_SIZE);
   localparam int EXT_W = (DIM_W > SIZE_REG_BITS) ? DIM_W : SIZE_REG_BITS;
   localparam int IDX_W = (DIM_W > COORD_BITS) ? DIM_W : COORD_BITS;
   localparam int ACC_A = COORD_BITS + 2 * DIM_W + 2;
   localparam int ACC_W = (ACC_A > INDEX_BITS) ? ACC_A : INDEX_BITS + 1;
   localparam int NCELL = COORD_BITS;

   typedef struct packed {
      logic [COORD_BITS-1:0] row_q;
      logic [COORD_BITS-1:0] col_q;
      logic [DIM_W-1:0]      col_r;
      logic [DIM_W-1:0]      row_r;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
   } passb_pay_type;

   typedef logic [MAX_RANK-1:0][IDX_W-1:0] idx_vec_type;

   // ---------------- configuration registers ----------------
   logic [RANK_BITS-1:0]     rank_ff;
   logic                     odd_row_ff;
   logic [SIZE_REG_BITS-1:0] size_ff [1:4];
   logic                     csr_wr;
   csr_reg_type              csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_sel = csr_reg_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff    <= RANK_BITS'(2);
         odd_row_ff <= 1'b0;
         for (int k = 1; k <= 4; k++) begin
            size_ff[k] <= SIZE_REG_BITS'(1);
         end
      end else if (csr_wr) begin
         unique case (csr_sel)
            CSR_RANK:      rank_ff    <= pwdata[RANK_BITS-1:0];
            CSR_ODD_ROW:   odd_row_ff <= pwdata[0];
            CSR_SIZE_DIM1: size_ff[1] <= pwdata[SIZE_REG_BITS-1:0];
            CSR_SIZE_DIM2: size_ff[2] <= pwdata[SIZE_REG_BITS-1:0];
            CSR_SIZE_DIM3: size_ff[3] <= pwdata[SIZE_REG_BITS-1:0];
            CSR_SIZE_DIM4: size_ff[4] <= pwdata[SIZE_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_RANK:      prdata = CSR_DATA_BITS'(rank_ff);
         CSR_ODD_ROW:   prdata = CSR_DATA_BITS'(odd_row_ff);
         CSR_SIZE_DIM1: prdata = CSR_DATA_BITS'(size_ff[1]);
         CSR_SIZE_DIM2: prdata = CSR_DATA_BITS'(size_ff[2]);
         CSR_SIZE_DIM3: prdata = CSR_DATA_BITS'(size_ff[3]);
         CSR_SIZE_DIM4: prdata = CSR_DATA_BITS'(size_ff[4]);
         default:       prdata = '0;
      endcase
   end

   // effective sizes: zero acts as one, oversize clamps
   logic [DIM_W-1:0] eff [1:4];
   logic [EXT_W-1:0] ext [1:4];

   always_comb begin
      for (int k = 1; k <= 4; k++) begin
         ext[k] = EXT_W'(size_ff[k]);
         if (ext[k] == '0) begin
            eff[k] = DIM_W'(1);
         end else if (ext[k] > EXT_W'(MAX_DIM_SIZE)) begin
            eff[k] = DIM_W'(MAX_DIM_SIZE);
         end else begin
            eff[k] = DIM_W'(ext[k]);
         end
      end
   end

   logic rank_ok;
   logic rank4, rank5;
   assign rank_ok = (rank_ff != '0) && (rank_ff <= RANK_BITS'(MAX_RANK));
   assign rank4   = (rank_ff == RANK_BITS'(4));
   assign rank5   = (rank_ff == RANK_BITS'(5));

   // divisors: lane 0 divides row, lane 1 divides col
   logic [1:0][DIM_W-1:0] div_a;
   logic [0:0][DIM_W-1:0] div_b;

   always_comb begin
      div_a[0] = eff[1];
      div_a[1] = eff[2];
      if (rank4) begin
         div_a[0] = eff[2];
         div_a[1] = eff[3];
      end else if (rank5) begin
         div_a[0] = eff[3];
         div_a[1] = eff[4];
      end
      div_b[0] = eff[1];
   end

   // ---------------- output buffer control ----------------
   logic            out_valid_ff, skid_valid_ff;
   rsp_payload_type out_ff, skid_ff;
   logic            en;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   // ---------------- first divider chain ----------------
   logic                       a_valid [0:NCELL];
   logic [1:0][DIM_W-1:0]      a_rem   [0:NCELL];
   logic [1:0][COORD_BITS-1:0] a_num   [0:NCELL];
   req_payload_type            a_pay   [0:NCELL];

   assign a_valid[0]  = req_valid & req_ready;
   assign a_rem[0]    = '0;
   assign a_num[0][0] = req_data.row;
   assign a_num[0][1] = req_data.col;
   assign a_pay[0]    = req_data;

   for (genvar g = 0; g < NCELL; g++) begin : g_pass_a
      tpi_div_cell #(
         .LANES (2),
         .NUM_W (COORD_BITS),
         .DIV_W (DIM_W),
         .PAY_W ($bits(req_payload_type))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .divisor  (div_a),
         .up_valid (a_valid[g]),
         .up_rem   (a_rem[g]),
         .up_num   (a_num[g]),
         .up_pay   (a_pay[g]),
         .dn_valid (a_valid[g+1]),
         .dn_rem   (a_rem[g+1]),
         .dn_num   (a_num[g+1]),
         .dn_pay   (a_pay[g+1])
      );
   end

   // ---------------- second divider chain (row quotient by size_dim1) ----------------
   logic                       b_valid [0:NCELL];
   logic [0:0][DIM_W-1:0]      b_rem   [0:NCELL];
   logic [0:0][COORD_BITS-1:0] b_num   [0:NCELL];
   passb_pay_type              b_pay   [0:NCELL];
   logic [COORD_BITS-1:0]      row_q;

   // the row quotient is divided again below, so a copy of it rides along
   assign row_q          = a_num[NCELL][0];
   assign b_valid[0]     = a_valid[NCELL];
   assign b_rem[0]       = '0;
   assign b_num[0][0]    = row_q;
   assign b_pay[0].row_q = row_q;
   assign b_pay[0].col_q = a_num[NCELL][1];
   assign b_pay[0].col_r = a_rem[NCELL][1];
   assign b_pay[0].row_r = a_rem[NCELL][0];
   assign b_pay[0].row   = a_pay[NCELL].row;
   assign b_pay[0].col   = a_pay[NCELL].col;

   for (genvar g = 0; g < NCELL; g++) begin : g_pass_b
      tpi_div_cell #(
         .LANES (1),
         .NUM_W (COORD_BITS),
         .DIV_W (DIM_W),
         .PAY_W ($bits(passb_pay_type))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .divisor  (div_b),
         .up_valid (b_valid[g]),
         .up_rem   (b_rem[g]),
         .up_num   (b_num[g]),
         .up_pay   (b_pay[g]),
         .dn_valid (b_valid[g+1]),
         .dn_rem   (b_rem[g+1]),
         .dn_num   (b_num[g+1]),
         .dn_pay   (b_pay[g+1])
      );
   end

   // ---------------- index selection ----------------
   passb_pay_type bp;
   idx_vec_type   idx;
   logic [COORD_BITS-1:0] row_q1;
   logic [DIM_W-1:0]      row_r1;

   assign bp     = b_pay[NCELL];
   assign row_q1 = b_num[NCELL][0];
   assign row_r1 = b_rem[NCELL][0];

   always_comb begin
      idx = '0;
      unique case (rank_ff)
         RANK_BITS'(1): begin
            idx[0] = odd_row_ff ? IDX_W'(bp.row) : IDX_W'(bp.col);
         end
         RANK_BITS'(2): begin
            idx[0] = IDX_W'(bp.row);
            idx[1] = IDX_W'(bp.col);
         end
         RANK_BITS'(3): begin
            if (odd_row_ff) begin
               idx[0] = IDX_W'(bp.row_q);
               idx[1] = IDX_W'(bp.row_r);
               idx[2] = IDX_W'(bp.col);
            end else begin
               idx[0] = IDX_W'(bp.col_q);
               idx[1] = IDX_W'(bp.row);
               idx[2] = IDX_W'(bp.col_r);
            end
         end
         RANK_BITS'(4): begin
            idx[0] = IDX_W'(bp.row_q);
            idx[1] = IDX_W'(bp.col_q);
            idx[2] = IDX_W'(bp.row_r);
            idx[3] = IDX_W'(bp.col_r);
         end
         RANK_BITS'(5): begin
            idx[0] = IDX_W'(row_q1);
            idx[1] = IDX_W'(row_r1);
            idx[2] = IDX_W'(bp.col_q);
            idx[3] = IDX_W'(bp.row_r);
            idx[4] = IDX_W'(bp.col_r);
         end
         default: ;
      endcase
   end

   // ---------------- Horner cells ----------------
   logic             h_valid [0:4];
   logic [ACC_W-1:0] h_acc   [0:4];
   idx_vec_type      h_pay   [0:4];

   assign h_valid[0] = b_valid[NCELL];
   assign h_acc[0]   = ACC_W'(idx[0]);
   assign h_pay[0]   = idx;

   for (genvar k = 1; k <= 4; k++) begin : g_horner
      tpi_horner_cell #(
         .ACC_W  (ACC_W),
         .SIZE_W (DIM_W),
         .IDX_W  (IDX_W),
         .PAY_W  ($bits(idx_vec_type))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .active   (rank_ff > RANK_BITS'(k)),
         .size     (eff[k]),
         .up_valid (h_valid[k-1]),
         .up_acc   (h_acc[k-1]),
         .up_idx   (h_pay[k-1][k]),
         .up_pay   (h_pay[k-1]),
         .dn_valid (h_valid[k]),
         .dn_acc   (h_acc[k]),
         .dn_pay   (h_pay[k])
      );
   end

   // ---------------- saturation and output buffer ----------------
   rsp_payload_type fin;
   logic            ovf, push, pop;

   assign ovf = |h_acc[4][ACC_W-1:INDEX_BITS];

   always_comb begin
      if (!rank_ok) begin
         fin.flat_index = '0;
         fin.overflow   = 1'b0;
      end else if (ovf) begin
         fin.flat_index = '1;
         fin.overflow   = 1'b1;
      end else begin
         fin.flat_index = h_acc[4][INDEX_BITS-1:0];
         fin.overflow   = 1'b0;
      end
   end

   assign push = en & h_valid[4];
   assign pop  = out_valid_ff & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= fin;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= fin;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // ---------------- assertions ----------------
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> skid_valid_ff && $stable(skid_ff))
      else $error("buffered result lost while the output stalled");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.overflow) |-> (&out_ff.flat_index))
      else $error("overflow flagged without a saturated index");

   a_bad_rank_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rank_ok) |-> (out_ff.flat_index == '0 && !out_ff.overflow))
      else $error("unsupported rank produced a nonzero index");

endmodule

/* sv/tpi_div_cell.sv */
module tpi_div_cell #(
   parameter int LANES = 1,
   parameter int NUM_W = 24,
   parameter int DIV_W = 13,
   parameter int PAY_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic [LANES-1:0][DIV_W-1:0]      divisor,
   input  logic                             up_valid,
   input  logic [LANES-1:0][DIV_W-1:0]      up_rem,
   input  logic [LANES-1:0][NUM_W-1:0]      up_num,
   input  logic [PAY_W-1:0]                 up_pay,
   output logic                             dn_valid,
   output logic [LANES-1:0][DIV_W-1:0]      dn_rem,
   output logic [LANES-1:0][NUM_W-1:0]      dn_num,
   output logic [PAY_W-1:0]                 dn_pay
);

   logic                        valid_ff;
   logic [LANES-1:0][DIV_W-1:0] rem_ff, rem_in;
   logic [LANES-1:0][NUM_W-1:0] num_ff, num_in;
   logic [PAY_W-1:0]            pay_ff;
   logic [LANES-1:0][DIV_W:0]   trial;

   // one restoring step: dividend bits shift out at the top, quotient bits in at the bottom
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         trial[l] = {up_rem[l], up_num[l][NUM_W-1]};
         if (trial[l] >= {1'b0, divisor[l]}) begin
            rem_in[l] = DIV_W'(trial[l] - {1'b0, divisor[l]});
            num_in[l] = {up_num[l][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[l] = trial[l][DIV_W-1:0];
            num_in[l] = {up_num[l][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         pay_ff <= up_pay;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_num   = num_ff;
   assign dn_pay   = pay_ff;

endmodule

/* sv/tpi_horner_cell.sv */
module tpi_horner_cell #(
   parameter int ACC_W  = 52,
   parameter int SIZE_W = 13,
   parameter int IDX_W  = 24,
   parameter int PAY_W  = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              active,
   input  logic [SIZE_W-1:0] size,
   input  logic              up_valid,
   input  logic [ACC_W-1:0]  up_acc,
   input  logic [IDX_W-1:0]  up_idx,
   input  logic [PAY_W-1:0]  up_pay,
   output logic              dn_valid,
   output logic [ACC_W-1:0]  dn_acc,
   output logic [PAY_W-1:0]  dn_pay
);

   logic             valid_ff;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [PAY_W-1:0] pay_ff;

   // acc = acc * size + idx for dimensions inside the rank, else pass through
   always_comb begin
      if (active) begin
         acc_in = ACC_W'(up_acc * size) + ACC_W'(up_idx);
      end else begin
         acc_in = up_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
         pay_ff <= up_pay;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_acc   = acc_ff;
   assign dn_pay   = pay_ff;

endmodule
